/* rtl/fbm_pkg.sv */
// Shared widths, constants and rounding helpers for the forward basis matrix unit.
// No dependencies.
`default_nettype none
package fbm_pkg;

	localparam int unsigned MAG_W   = 30;
	localparam int unsigned SUM_W   = 62;
	localparam int unsigned ROOT_W  = SUM_W / 2;
	localparam int unsigned REM_W   = ROOT_W + 4;
	localparam int unsigned FRAC_SH = 15;
	localparam int unsigned NUM_W   = MAG_W + FRAC_SH + 1;
	localparam int unsigned DEN_W   = ROOT_W + 1;
	localparam int unsigned QUO_W   = 15;
	localparam int unsigned DIR_SH  = 14;

	localparam int ONE_Q14 = 16384;
	localparam int HELP_X  = 16;
	localparam int HELP_Y  = 16384;

	typedef logic signed [15:0] s16_t;
	typedef logic signed [31:0] s32_t;

	function automatic logic [15:0] abs16(input s16_t v);
		return v[15] ? 16'(-v) : v;
	endfunction

	// x / 2^14 rounded half up
	function automatic logic signed [19:0] rnd_q14(input logic signed [32:0] x);
		logic signed [33:0] t;
		t = 34'(x) + 34'sd8192;
		return 20'(t >>> 14);
	endfunction

	function automatic s16_t clamp_q14(input logic signed [19:0] v);
		if (v > 20'sd16384)
			return 16'sd16384;
		else if (v < -20'sd16384)
			return -16'sd16384;
		else
			return 16'(v);
	endfunction

	function automatic s16_t sat16(input logic signed [19:0] v);
		if (v > 20'sd32767)
			return 16'sd32767;
		else if (v < -20'sd32768)
			return -16'sd32768;
		else
			return 16'(v);
	endfunction

endpackage
`default_nettype wire

/* rtl/fbm_norm.sv */
// Pipelined three-lane vector normaliser: squares, digit-by-digit square root,
// restoring divide per lane. Depends on fbm_pkg.
`default_nettype none
module fbm_norm import fbm_pkg::*; #(
	parameter int unsigned PAY_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [MAG_W-1:0] in_mag [3],
	input  logic [2:0]       in_neg,
	input  logic [PAY_W-1:0] in_pay,
	output logic             out_valid,
	output s16_t             out_comp [3],
	output logic [PAY_W-1:0] out_pay
);

	localparam int unsigned SQ_W = 2 * MAG_W;

	logic             v_s1;
	logic [MAG_W-1:0] mag_s1 [3];
	logic [2:0]       neg_s1;
	logic [PAY_W-1:0] pay_s1;
	logic [SQ_W-1:0]  sq_s1 [3];

	logic             v_rt    [ROOT_W+1];
	logic [SUM_W-1:0] x_rt    [ROOT_W+1];
	logic [REM_W-1:0] rem_rt  [ROOT_W+1];
	logic [ROOT_W-1:0] root_rt [ROOT_W+1];
	logic [MAG_W-1:0] mag_rt  [ROOT_W+1][3];
	logic [2:0]       neg_rt  [ROOT_W+1];
	logic [PAY_W-1:0] pay_rt  [ROOT_W+1];

	logic [REM_W-1:0]  rem_n  [ROOT_W];
	logic [ROOT_W-1:0] root_n [ROOT_W];

	logic             v_dv    [QUO_W+1];
	logic [NUM_W-1:0] rem_dv  [QUO_W+1][3];
	logic [QUO_W-1:0] quo_dv  [QUO_W+1][3];
	logic [DEN_W-1:0] den_dv  [QUO_W+1];
	logic             zero_dv [QUO_W+1];
	logic [2:0]       neg_dv  [QUO_W+1];
	logic [PAY_W-1:0] pay_dv  [QUO_W+1];

	logic [NUM_W-1:0] drem_n [QUO_W][3];
	logic [QUO_W-1:0] dquo_n [QUO_W][3];

	logic             v_o_q;
	s16_t             comp_q [3];
	logic [PAY_W-1:0] pay_o_q;

	always_comb begin
		logic [REM_W-1:0] remsh;
		logic [REM_W-1:0] trial;
		for (int k = 0; k < ROOT_W; k++) begin
			remsh = {rem_rt[k][REM_W-3:0], x_rt[k][SUM_W-2-2*k +: 2]};
			trial = REM_W'({root_rt[k], 2'b01});
			if (remsh >= trial) begin
				rem_n[k]  = remsh - trial;
				root_n[k] = {root_rt[k][ROOT_W-2:0], 1'b1};
			end else begin
				rem_n[k]  = remsh;
				root_n[k] = {root_rt[k][ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		logic [NUM_W-1:0] dtrial;
		for (int j = 0; j < QUO_W; j++) begin
			dtrial = NUM_W'(den_dv[j]) << (QUO_W - 1 - j);
			for (int i = 0; i < 3; i++) begin
				if (rem_dv[j][i] >= dtrial) begin
					drem_n[j][i] = rem_dv[j][i] - dtrial;
					dquo_n[j][i] = {quo_dv[j][i][QUO_W-2:0], 1'b1};
				end else begin
					drem_n[j][i] = rem_dv[j][i];
					dquo_n[j][i] = {quo_dv[j][i][QUO_W-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_o_q <= 1'b0;
			for (int k = 0; k <= ROOT_W; k++)
				v_rt[k] <= 1'b0;
			for (int j = 0; j <= QUO_W; j++)
				v_dv[j] <= 1'b0;
		end else if (en) begin
			v_s1    <= in_valid;
			v_rt[0] <= v_s1;
			for (int k = 0; k < ROOT_W; k++)
				v_rt[k+1] <= v_rt[k];
			v_dv[0] <= v_rt[ROOT_W];
			for (int j = 0; j < QUO_W; j++)
				v_dv[j+1] <= v_dv[j];
			v_o_q <= v_dv[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		logic [QUO_W-1:0] q;
		s16_t             qs;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_s1[i] <= in_mag[i];
				sq_s1[i]  <= SQ_W'(in_mag[i]) * SQ_W'(in_mag[i]);
			end
			neg_s1 <= in_neg;
			pay_s1 <= in_pay;

			x_rt[0]    <= SUM_W'(sq_s1[0]) + SUM_W'(sq_s1[1]) + SUM_W'(sq_s1[2]);
			rem_rt[0]  <= '0;
			root_rt[0] <= '0;
			mag_rt[0]  <= mag_s1;
			neg_rt[0]  <= neg_s1;
			pay_rt[0]  <= pay_s1;
			for (int k = 0; k < ROOT_W; k++) begin
				x_rt[k+1]    <= x_rt[k];
				rem_rt[k+1]  <= rem_n[k];
				root_rt[k+1] <= root_n[k];
				mag_rt[k+1]  <= mag_rt[k];
				neg_rt[k+1]  <= neg_rt[k];
				pay_rt[k+1]  <= pay_rt[k];
			end

			for (int i = 0; i < 3; i++) begin
				rem_dv[0][i] <= NUM_W'({mag_rt[ROOT_W][i], FRAC_SH'(0)})
					+ NUM_W'(root_rt[ROOT_W]);
				quo_dv[0][i] <= '0;
			end
			den_dv[0]  <= {root_rt[ROOT_W], 1'b0};
			zero_dv[0] <= (root_rt[ROOT_W] == '0);
			neg_dv[0]  <= neg_rt[ROOT_W];
			pay_dv[0]  <= pay_rt[ROOT_W];
			for (int j = 0; j < QUO_W; j++) begin
				rem_dv[j+1]  <= drem_n[j];
				quo_dv[j+1]  <= dquo_n[j];
				den_dv[j+1]  <= den_dv[j];
				zero_dv[j+1] <= zero_dv[j];
				neg_dv[j+1]  <= neg_dv[j];
				pay_dv[j+1]  <= pay_dv[j];
			end

			for (int i = 0; i < 3; i++) begin
				q = quo_dv[QUO_W][i];
				if (zero_dv[QUO_W])
					q = '0;
				else if (q > QUO_W'(ONE_Q14))
					q = QUO_W'(ONE_Q14);
				qs = s16_t'({1'b0, q});
				comp_q[i] <= neg_dv[QUO_W][i] ? -qs : qs;
			end
			pay_o_q <= pay_dv[QUO_W];
		end
	end

	assign out_valid = v_o_q;
	assign out_comp  = comp_q;
	assign out_pay   = pay_o_q;

endmodule
`default_nettype wire

/* rtl/forward_basis_matrix_unit.sv */
// Top level: front normaliser, helper cross product, right normaliser, up cross
// product and row scaling. Depends on fbm_pkg and fbm_norm.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------
//  item     | item_valid / item_ready    | dir_x/y/z, scale_x/y/z
//  result   | result_valid / result_ready| m11..m33, unit_front_x/y/z
//
// One transfer per cycle in and one per cycle out unless a result waits on
// result_ready. Each normaliser has square, sum, 31 root steps, divide load,
// 15 quotient steps and output stages; then follow the cross stage, the up
// product and difference stages, and the matrix product and saturation stages.
// The whole pipeline advances together; item_ready is low only while a result
// waits on result_ready. Reset clears the valid bits only.
`default_nettype none
module forward_basis_matrix_unit import fbm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  s16_t dir_x,
	input  s16_t dir_y,
	input  s16_t dir_z,
	input  s16_t scale_x,
	input  s16_t scale_y,
	input  s16_t scale_z,
	output logic result_valid,
	input  logic result_ready,
	output s16_t m11,
	output s16_t m12,
	output s16_t m13,
	output s16_t m21,
	output s16_t m22,
	output s16_t m23,
	output s16_t m31,
	output s16_t m32,
	output s16_t m33,
	output s16_t unit_front_x,
	output s16_t unit_front_y,
	output s16_t unit_front_z
);

	localparam int unsigned P1_W = 48;
	localparam int unsigned P2_W = 96;

	logic en;

	logic [MAG_W-1:0] n1_mag [3];
	logic [2:0]       n1_neg;
	logic             n1_v;
	s16_t             front [3];
	logic [P1_W-1:0]  n1_pay;

	s32_t             cr [3];
	logic             v_s1;
	logic [MAG_W-1:0] crmag_s1 [3];
	logic [2:0]       crneg_s1;
	logic [P2_W-1:0]  pay_s1;

	logic             n2_v;
	s16_t             right [3];
	logic [P2_W-1:0]  n2_pay;

	logic v_s2, v_s3, v_s4, v_s5;
	s32_t prod_s2 [6];
	s16_t r_s2 [3], f_s2 [3], sc_s2 [3];
	s16_t up_s3 [3], r_s3 [3], f_s3 [3], sc_s3 [3];
	s32_t mp_s4 [9];
	s16_t f_s4 [3];
	s16_t m_s5 [9];
	s16_t f_s5 [3];

	assign en         = ~v_s5 | result_ready;
	assign item_ready = en;

	assign n1_mag[0] = MAG_W'({abs16(dir_x), DIR_SH'(0)});
	assign n1_mag[1] = MAG_W'({abs16(dir_y), DIR_SH'(0)});
	assign n1_mag[2] = MAG_W'({abs16(dir_z), DIR_SH'(0)});
	assign n1_neg    = {dir_z[15], dir_y[15], dir_x[15]};

	fbm_norm #(.PAY_W(P1_W)) u_norm_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (item_valid),
		.in_mag   (n1_mag),
		.in_neg   (n1_neg),
		.in_pay   ({scale_z, scale_y, scale_x}),
		.out_valid(n1_v),
		.out_comp (front),
		.out_pay  (n1_pay)
	);

	// helper x front, helper held as Q1.14 (16, 16384, 0)
	assign cr[0] = HELP_Y * front[2];
	assign cr[1] = -(HELP_X * front[2]);
	assign cr[2] = HELP_X * front[1] - HELP_Y * front[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= n1_v;
			v_s2 <= n2_v;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				crmag_s1[i] <= MAG_W'(cr[i][31] ? -cr[i] : cr[i]);
				crneg_s1[i] <= cr[i][31];
			end
			pay_s1 <= {n1_pay, front[2], front[1], front[0]};

			for (int i = 0; i < 3; i++) begin
				r_s2[i]  <= right[i];
				f_s2[i]  <= n2_pay[16*i +: 16];
				sc_s2[i] <= n2_pay[48 + 16*i +: 16];
			end
			prod_s2[0] <= s16_t'(n2_pay[31:16]) * right[2];
			prod_s2[1] <= s16_t'(n2_pay[47:32]) * right[1];
			prod_s2[2] <= s16_t'(n2_pay[47:32]) * right[0];
			prod_s2[3] <= s16_t'(n2_pay[15:0]) * right[2];
			prod_s2[4] <= s16_t'(n2_pay[15:0]) * right[1];
			prod_s2[5] <= s16_t'(n2_pay[31:16]) * right[0];

			for (int i = 0; i < 3; i++)
				up_s3[i] <= clamp_q14(rnd_q14(33'(prod_s2[2*i]) - 33'(prod_s2[2*i+1])));
			r_s3  <= r_s2;
			f_s3  <= f_s2;
			sc_s3 <= sc_s2;

			for (int j = 0; j < 3; j++) begin
				mp_s4[j]     <= r_s3[j]  * sc_s3[0];
				mp_s4[3 + j] <= up_s3[j] * sc_s3[1];
				mp_s4[6 + j] <= f_s3[j]  * sc_s3[2];
			end
			f_s4 <= f_s3;

			for (int k = 0; k < 9; k++)
				m_s5[k] <= sat16(rnd_q14(33'(mp_s4[k])));
			f_s5 <= f_s4;
		end
	end

	fbm_norm #(.PAY_W(P2_W)) u_norm_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s1),
		.in_mag   (crmag_s1),
		.in_neg   (crneg_s1),
		.in_pay   (pay_s1),
		.out_valid(n2_v),
		.out_comp (right),
		.out_pay  (n2_pay)
	);

	assign result_valid = v_s5;
	assign m11 = m_s5[0];
	assign m12 = m_s5[1];
	assign m13 = m_s5[2];
	assign m21 = m_s5[3];
	assign m22 = m_s5[4];
	assign m23 = m_s5[5];
	assign m31 = m_s5[6];
	assign m32 = m_s5[7];
	assign m33 = m_s5[8];
	assign unit_front_x = f_s5[0];
	assign unit_front_y = f_s5[1];
	assign unit_front_z = f_s5[2];

endmodule
`default_nettype wire

/* rtl/fbm_checker.sv */
// Port-level checks for forward_basis_matrix_unit, bound to the top level.
// Depends on fbm_pkg.
`default_nettype none
module fbm_checker import fbm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input s16_t dir_x,
	input s16_t dir_y,
	input s16_t dir_z,
	input s16_t scale_x,
	input s16_t scale_y,
	input s16_t scale_z,
	input logic result_valid,
	input logic result_ready,
	input s16_t m11,
	input s16_t m12,
	input s16_t m13,
	input s16_t m21,
	input s16_t m22,
	input s16_t m23,
	input s16_t m31,
	input s16_t m32,
	input s16_t m33,
	input s16_t unit_front_x,
	input s16_t unit_front_y,
	input s16_t unit_front_z
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_ready |=> item_valid && $stable(dir_x) && $stable(dir_y)
			&& $stable(dir_z) && $stable(scale_x) && $stable(scale_y) && $stable(scale_z))
		else $error("input transfer withdrawn or changed while waiting");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid
			&& $stable(m11) && $stable(m12) && $stable(m13)
			&& $stable(m21) && $stable(m22) && $stable(m23)
			&& $stable(m31) && $stable(m32) && $stable(m33)
			&& $stable(unit_front_x) && $stable(unit_front_y) && $stable(unit_front_z))
		else $error("result dropped or changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		result_ready |-> item_ready)
		else $error("input stalled although output drains");

	a_unit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> unit_front_x <= 16'sd16384 && unit_front_x >= -16'sd16384
			&& unit_front_y <= 16'sd16384 && unit_front_y >= -16'sd16384
			&& unit_front_z <= 16'sd16384 && unit_front_z >= -16'sd16384)
		else $error("front out of Q1.14 unit range");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && unit_front_x == 0 && unit_front_y == 0 && unit_front_z == 0
		|-> m11 == 0 && m12 == 0 && m13 == 0 && m21 == 0 && m22 == 0 && m23 == 0
			&& m31 == 0 && m32 == 0 && m33 == 0)
		else $error("zero front with non-zero matrix");

endmodule

bind forward_basis_matrix_unit fbm_checker u_fbm_checker (.*);
`default_nettype wire
